@@ rtl/pds_pkg.sv @@
`timescale 1ns / 1ps
package pds_pkg;

  localparam logic signed [4:0] P_MIN = 5'sd0;
  localparam logic signed [4:0] P_MAX = 5'sd3;
  localparam int POST_MUL = 1;
  localparam int POST_DIV = 1;
  localparam logic [15:0] MUL_MIN = 16'd1;
  localparam logic [15:0] DIV_MIN = 16'd1;
  localparam logic [39:0] RATIO_LIMIT = 40'h0010_0000;
  localparam logic [39:0] ERR_LIMIT = 40'h00_7FFF_FFFF;
  localparam logic [63:0] MAX31 = 64'h7FFF_FFFF;

  localparam int DIV_W = 56;
  localparam int DVS_W = 40;

  typedef enum logic [1:0] {
    K_PROPOSE = 2'd0,
    K_LOWER   = 2'd1,
    K_RAISE   = 2'd2,
    K_CHECK   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    R_REF_FREQ = 3'd0,
    R_VCO_MIN  = 3'd1,
    R_VCO_MAX  = 3'd2,
    R_MUL_MAX  = 3'd3,
    R_DIV_MAX  = 3'd4,
    R_CLK_MIN  = 3'd5,
    R_CLK_MAX  = 3'd6
  } reg_idx_t;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_MUL   = 16'h0002,
    S_DIV   = 16'h0004,
    S_CLAMP = 16'h0008,
    S_PLO   = 16'h0010,
    S_PHI   = 16'h0020,
    S_PCHK  = 16'h0040,
    S_DBL   = 16'h0080,
    S_RATIO = 16'h0100,
    S_SCL   = 16'h0200,
    S_RND   = 16'h0400,
    S_EVAL  = 16'h0800,
    S_FIN   = 16'h1000,
    S_OF    = 16'h2000,
    S_ND    = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  // a 5-bit exponent never exceeds 15, so no cap is needed on the left shift
  function automatic logic [63:0] shift_by(input logic [63:0] v, input logic signed [4:0] p);
    logic [4:0] amt;
    amt = 5'd0;
    if (p >= 0) begin
      amt = p[4:0];
      return v << amt;
    end else begin
      amt = 5'(-p);
      return v >> amt;
    end
  endfunction

  function automatic logic [30:0] sat31(input logic [63:0] v);
    return (v > MAX31) ? 31'h7FFF_FFFF : v[30:0];
  endfunction

endpackage

@@ rtl/pll_divider_search_unit.sv @@
`timescale 1ns / 1ps
// PLL divider search. One request word at a time: in_ready is high only while the unit is
// idle. A propose request or one with a zero ratio goes straight to the result. Otherwise
// the work runs through one shared 40x16 multiplier feeding a restoring divider: one
// multiply-divide pass forms the pixel clock (an out-of-range request is rejected right
// after it), the VCO is placed and the ratio scaled, then every step of the mul/div search
// (over the narrower of the two ranges, ending early once the paired value runs past its
// limit) takes one multiply-divide pass, plus a pass for the output clock and, for lower
// and raise requests, one for the adjusted dot clock. A finished result waits in the
// output register while the next request is taken.
module pll_divider_search_unit
  import pds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [30:0] dot_clock,
  input  logic [15:0] ratio_mul,
  input  logic [15:0] ratio_div,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [15:0] feedback_mul,
  output logic [15:0] ref_div,
  output logic signed [4:0] post_shift,
  output logic [30:0] vco_freq,
  output logic [30:0] out_freq,
  output logic [30:0] new_dot_clock
);

  logic [30:0] ref_freq, vco_min, vco_max, clk_min, clk_max;
  logic [15:0] mul_max, div_max;

  state_t state, ret;
  kind_t  kind_q;
  logic [15:0] rmul_q, rdiv_q;

  logic [DVS_W-1:0] mul_a, dvs, rem;
  logic [15:0] mul_b;
  logic [DIV_W-1:0] num;
  logic [5:0] cnt;

  logic [46:0] f;
  logic signed [4:0] p;
  logic [30:0] vco;
  logic [39:0] rm, rd, best;
  logic [5:0] s;
  logic mulbr, first, found;
  logic [15:0] idx, bidx;
  logic [56:0] both;

  logic        r_status;
  logic [15:0] r_mul, r_div;
  logic signed [4:0] r_p;
  logic [30:0] r_vco, r_of, r_nd;

  logic lower;
  logic [DVS_W:0] rem_sh;
  logic ge;
  logic [46:0] nf, fc;
  logic [63:0] fvco_c, fq;
  logic [39:0] low;
  logic [56:0] other, bm, bd;
  logic [15:0] idx_max, lim;
  logic [39:0] err;
  logic adj;

  assign in_ready = (state == S_IDLE);
  assign lower = (kind_q != K_RAISE);
  assign rem_sh = {rem, num[DIV_W-1]};
  assign ge = (rem_sh >= {1'b0, dvs});
  assign nf = num[46:0];
  assign fvco_c = shift_by({17'b0, f}, p);
  assign fq = shift_by(64'(num) * POST_MUL / POST_DIV, 5'(-p));
  assign low = (40'd1 << s) - 40'd1;
  assign adj = (lower == mulbr);
  assign other = {1'b0, num} + 57'(adj);
  assign err = adj ? (dvs - rem) : rem;
  assign idx_max = mulbr ? mul_max : div_max;
  assign lim = mulbr ? div_max : mul_max;
  assign bm = mulbr ? 57'(bidx) : both;
  assign bd = mulbr ? both : 57'(bidx);

  always_comb begin
    fc = nf;
    if (kind_q == K_LOWER && nf > 47'(clk_max)) begin
      fc = 47'(clk_max);
    end else if (kind_q == K_RAISE && nf < 47'(clk_min)) begin
      fc = 47'(clk_min);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq <= 31'd14318180;
      vco_min  <= 31'd100000000;
      vco_max  <= 31'd250000000;
      mul_max  <= 16'd255;
      div_max  <= 16'd63;
      clk_min  <= 31'd10000000;
      clk_max  <= 31'd220000000;
    end else if (cfg_we) begin
      case (cfg_index)
        R_REF_FREQ: ref_freq <= cfg_data;
        R_VCO_MIN:  vco_min  <= cfg_data;
        R_VCO_MAX:  vco_max  <= cfg_data;
        R_MUL_MAX:  mul_max  <= cfg_data[15:0];
        R_DIV_MAX:  div_max  <= cfg_data[15:0];
        R_CLK_MIN:  clk_min  <= cfg_data;
        R_CLK_MAX:  clk_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind_t'(kind);
            rmul_q <= ratio_mul;
            rdiv_q <= ratio_div;
            r_status <= 1'b0;
            r_mul <= '0;
            r_div <= '0;
            r_p <= '0;
            r_vco <= '0;
            r_of <= '0;
            r_nd <= dot_clock;
            mul_a <= 40'(dot_clock);
            mul_b <= ratio_mul;
            dvs <= 40'(ratio_div);
            ret <= S_CLAMP;
            if (kind_t'(kind) == K_PROPOSE) begin
              state <= S_DONE;
            end else if (ratio_mul == 16'd0 || ratio_div == 16'd0) begin
              r_status <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          num <= DIV_W'(mul_a) * DIV_W'(mul_b);
          rem <= '0;
          cnt <= 6'(DIV_W);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
          num <= {num[DIV_W-2:0], ge};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= ret;
        end
        S_CLAMP: begin
          f <= fc;
          if ((kind_q == K_LOWER && nf < 47'(clk_min)) ||
              (kind_q == K_RAISE && nf > 47'(clk_max))) begin
            r_status <= 1'b1;
            state <= S_DONE;
          end else if (fc < 47'(vco_min)) begin
            p <= P_MIN;
            state <= S_PLO;
          end else if (fc > 47'(vco_max)) begin
            p <= (P_MAX > 5'sd0) ? 5'sd0 : P_MAX;
            state <= S_PHI;
          end else begin
            p <= 5'sd0;
            state <= S_DBL;
          end
        end
        S_PLO: begin
          if (fvco_c < 64'(vco_min) && p < P_MAX) p <= p + 5'sd1;
          else state <= S_PCHK;
        end
        S_PHI: begin
          if (fvco_c > 64'(vco_max) && p > P_MIN) p <= p - 5'sd1;
          else state <= S_PCHK;
        end
        S_PCHK: begin
          if (fvco_c < 64'(vco_min) || fvco_c > 64'(vco_max) || p < P_MIN || p > P_MAX) begin
            r_status <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_DBL;
          end
        end
        S_DBL: begin
          if ((fvco_c << 1) < 64'(vco_max) && p < P_MAX) p <= p + 5'sd1;
          state <= S_RATIO;
        end
        S_RATIO: begin
          vco <= fvco_c[30:0];
          rm <= 40'(fvco_c[30:0]) * POST_DIV;
          rd <= 40'(ref_freq) * POST_MUL;
          s <= '0;
          state <= S_SCL;
        end
        S_SCL: begin
          if (s < 6'd62 && (rm >> s) > RATIO_LIMIT && (rd >> s) > RATIO_LIMIT) s <= s + 6'd1;
          else state <= S_RND;
        end
        S_RND: begin
          logic [39:0] rm_n, rd_n;
          if (lower) begin
            rm_n = rm >> s;
            rd_n = (rd >= low) ? ((rd - low) >> s) : '0;
          end else begin
            rm_n = (rm >= low) ? ((rm - low) >> s) : '0;
            rd_n = rd >> s;
          end
          rm <= rm_n;
          rd <= rd_n;
          if (rm_n == '0 || rd_n == '0) begin
            r_status <= 1'b1;
            state <= S_DONE;
          end else begin
            mulbr <= ($signed({2'b0, mul_max}) - $signed({2'b0, MUL_MIN})) <
                     ($signed({2'b0, div_max}) - $signed({2'b0, DIV_MIN}));
            if (($signed({2'b0, mul_max}) - $signed({2'b0, MUL_MIN})) <
                ($signed({2'b0, div_max}) - $signed({2'b0, DIV_MIN}))) begin
              idx <= MUL_MIN;
              mul_a <= rd_n;
              mul_b <= MUL_MIN;
              dvs <= rm_n;
            end else begin
              idx <= DIV_MIN;
              mul_a <= rm_n;
              mul_b <= DIV_MIN;
              dvs <= rd_n;
            end
            best <= ERR_LIMIT;
            found <= 1'b0;
            first <= 1'b1;
            ret <= S_EVAL;
            state <= S_MUL;
          end
        end
        S_EVAL: begin
          if ((!first && other > 57'(lim)) || idx >= idx_max) begin
            state <= S_FIN;
          end else begin
            if (err < best) begin
              best <= err;
              bidx <= idx;
              both <= other;
              found <= 1'b1;
            end
            idx <= idx + 16'd1;
            mul_b <= idx + 16'd1;
            first <= 1'b0;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (!found || bm < 57'(MUL_MIN) || bm > 57'(mul_max) ||
              bd < 57'(DIV_MIN) || bd > 57'(div_max)) begin
            r_status <= 1'b1;
            state <= S_DONE;
          end else begin
            r_mul <= bm[15:0];
            r_div <= bd[15:0];
            r_p <= p;
            r_vco <= vco;
            mul_a <= 40'(ref_freq);
            mul_b <= bm[15:0];
            dvs <= 40'(bd[15:0]);
            ret <= S_OF;
            state <= S_MUL;
          end
        end
        S_OF: begin
          r_of <= sat31(fq);
          if (kind_q == K_LOWER || kind_q == K_RAISE) begin
            mul_a <= 40'(sat31(fq));
            mul_b <= rdiv_q;
            dvs <= 40'(rmul_q);
            ret <= S_ND;
            state <= S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_ND: begin
          r_nd <= sat31(64'(num));
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= r_status;
            feedback_mul <= r_mul;
            ref_div <= r_div;
            post_shift <= r_p;
            vco_freq <= r_vco;
            out_freq <= r_of;
            new_dot_clock <= r_nd;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/pds_checker.sv @@
`timescale 1ns / 1ps
module pds_checker
  import pds_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [15:0] feedback_mul,
  input logic [15:0] ref_div,
  input logic [30:0] vco_freq,
  input logic [30:0] out_freq
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(feedback_mul) && $stable(status))
    else $error("result word dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> feedback_mul == 16'd0 && ref_div == 16'd0 &&
      vco_freq == 31'd0 && out_freq == 31'd0)
    else $error("failed result carries settings");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && feedback_mul != 16'd0 |-> ref_div != 16'd0 && vco_freq != 31'd0)
    else $error("incomplete setting");

endmodule

bind pll_divider_search_unit pds_checker u_pds_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .feedback_mul(feedback_mul), .ref_div(ref_div), .vco_freq(vco_freq),
  .out_freq(out_freq)
);
